FILE: hw/rtl/mtg_pkg.sv
// mtg_pkg: shared types, constants and tempering function for the MT19937 generator.
// No dependencies; used by mtg_ram, mtg_seeder, mt19937_generator and the bench.
package mtg_pkg;

  // State array geometry
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned N_WORDS = 624;
  localparam int unsigned M_SHIFT = 397;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_WORDS - 1);
  localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(N_WORDS);
  localparam logic [IDX_W-1:0] FAR_OFS  = IDX_W'(M_SHIFT);
  localparam logic [IDX_W-1:0] FAR_WRAP = IDX_W'(N_WORDS - M_SHIFT);

  // Algorithm constants
  localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] INIT_MULT = 32'h6C07_8965;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hEFC6_0000;

  // Command codes
  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_TWIST,
    ST_DRAW_OUT
  } state_t;

  // Controls from the sequencer to the seeding datapath
  typedef struct packed {
    logic load;    // take the seed as the previous word
    logic mul_en;  // register the multiply of the previous word
    logic add_en;  // add the index; result becomes the previous word
  } seed_ctl_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: hw/rtl/mt19937_generator.sv
// mt19937_generator: top level; command sequencer, twist pipeline and output tempering.
// Depends on mtg_pkg, mtg_ram and mtg_seeder.
//
//  port group  | dir | beat
//  ------------+-----+-----------------------------------------------------------
//  in_*        | in  | start && !busy; in_opcode (0 reseed, 1 draw), in_seed_value
//  out_*       | out | out_valid strobe, one cycle; out_random_word
//
// A draw passes the memory read register, then tempering into the output register.
// A draw at read position zero first twists all 624 words through the memory,
// one word per cycle, then reads and tempers its word as above.
// A reseed writes word 0, then each word after a multiply, then an add; busy until done.
// A draw before any reseed strobes 0 the next cycle. Reset clears the position,
// the seeded flag and the sequencer; the state words are unknown until a reseed.
// The receiver cannot stall: each out_valid beat is taken in its cycle.
module mt19937_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  output logic [31:0] out_random_word
);
  import mtg_pkg::*;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               ph_r, ph_nxt;
  logic               seeded_r, seeded_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [WORD_W-1:0]  cur_r;

  logic               accept;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]   raddr_a, raddr_b;
  logic [WORD_W-1:0]  rdata_a, rdata_b;
  seed_ctl_t          seed_ctl;
  logic [WORD_W-1:0]  seed_word;

  logic [IDX_W-1:0]   nxt_idx, far_idx;
  logic [WORD_W-1:0]  twist_y, twist_v;

  assign accept = start && !busy;

  mtg_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mtg_seeder u_seeder (
    .clk  (clk),
    .ctl  (seed_ctl),
    .seed (in_seed_value),
    .idx  (idx_r),
    .word (seed_word)
  );

  // neighbor and far addresses of the word being read for the twist
  assign nxt_idx = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign far_idx = (idx_r < FAR_WRAP) ? idx_r + FAR_OFS : idx_r - FAR_WRAP;

  // twist of word idx_r-1: cur_r holds it, rdata_a its neighbor, rdata_b the far word
  assign twist_y = {cur_r[WORD_W-1], rdata_a[WORD_W-2:0]};
  assign twist_v = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);

  // current word follows the neighbor read during the twist
  always_ff @(posedge clk) begin
    if (state_r == ST_TWIST) begin
      cur_r <= rdata_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pos_r       <= '0;
      ph_r        <= 1'b0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      ph_r        <= ph_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    ph_nxt        = ph_r;
    seeded_nxt    = seeded_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = seed_word;
    raddr_a       = pos_r;
    raddr_b       = far_idx;
    seed_ctl      = '0;
    busy          = 1'b1;

    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (in_opcode == OP_RESEED) begin
            // word 0 is the seed itself
            mem_we        = 1'b1;
            mem_waddr     = '0;
            mem_wdata     = in_seed_value;
            seed_ctl.load = 1'b1;
            idx_nxt       = IDX_W'(1);
            ph_nxt        = 1'b0;
            state_nxt     = ST_SEED;
          end else if (!seeded_r) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '0;
          end else if (pos_r == '0) begin
            // prime the twist with word 0
            raddr_a   = '0;
            idx_nxt   = '0;
            state_nxt = ST_TWIST;
          end else begin
            raddr_a   = pos_r;
            state_nxt = ST_DRAW_OUT;
          end
        end
      end

      ST_SEED: begin
        if (!ph_r) begin
          seed_ctl.mul_en = 1'b1;
          ph_nxt          = 1'b1;
        end else begin
          seed_ctl.add_en = 1'b1;
          mem_we          = 1'b1;
          mem_waddr       = idx_r;
          mem_wdata       = seed_word;
          ph_nxt          = 1'b0;
          if (idx_r == LAST_IDX) begin
            pos_nxt    = '0;
            seeded_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_TWIST: begin
        // write back word idx_r-1 while reading for word idx_r
        mem_we    = (idx_r != '0);
        mem_waddr = idx_r - 1'b1;
        mem_wdata = twist_v;
        if (idx_r == END_IDX) begin
          raddr_a   = pos_r;
          state_nxt = ST_DRAW_OUT;
        end else begin
          raddr_a = nxt_idx;
          raddr_b = far_idx;
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_DRAW_OUT: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = temper(rdata_a);
        pos_nxt       = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // checks
  a_twist_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TWIST && mem_we && idx_r != END_IDX) |->
      (mem_waddr != raddr_a && mem_waddr != raddr_b))
    else $error("twist write collides with a read of the same word");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_IDX)
    else $error("read position out of range");

  a_draw_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW_OUT) |=> (out_valid && state_r == ST_IDLE))
    else $error("draw did not produce a beat");

  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped");

  a_seed_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED && mem_we) |-> (ph_r && idx_r != '0))
    else $error("seed write outside its add phase");

endmodule

FILE: hw/rtl/mtg_ram.sv
// mtg_ram: 624 x 32 state memory, one write port and two registered read ports.
// Read-first behavior on a same-address read and write. Depends on mtg_pkg.
module mtg_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [mtg_pkg::IDX_W-1:0]  waddr,
  input  logic [mtg_pkg::WORD_W-1:0] wdata,
  input  logic [mtg_pkg::IDX_W-1:0]  raddr_a,
  input  logic [mtg_pkg::IDX_W-1:0]  raddr_b,
  output logic [mtg_pkg::WORD_W-1:0] rdata_a,
  output logic [mtg_pkg::WORD_W-1:0] rdata_b
);
  import mtg_pkg::*;

  logic [WORD_W-1:0] mem [N_WORDS];
  logic [WORD_W-1:0] rdata_a_r;
  logic [WORD_W-1:0] rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: hw/rtl/mtg_seeder.sv
// mtg_seeder: seeding recurrence w[i] = INIT_MULT * (w[i-1] ^ (w[i-1] >> 30)) + i.
// Each word takes a registered multiply, then an add. Depends on mtg_pkg.
module mtg_seeder (
  input  logic                       clk,
  input  mtg_pkg::seed_ctl_t         ctl,
  input  logic [mtg_pkg::WORD_W-1:0] seed,
  input  logic [mtg_pkg::IDX_W-1:0]  idx,
  output logic [mtg_pkg::WORD_W-1:0] word
);
  import mtg_pkg::*;

  logic [WORD_W-1:0] prev_r;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] sum;

  assign sum  = prod_r + {{(WORD_W-IDX_W){1'b0}}, idx};
  assign word = sum;

  // previous word register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prev_r <= seed;
    end else if (ctl.add_en) begin
      prev_r <= sum;
    end
  end

  // multiply stage, low 32 bits kept
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= INIT_MULT * (prev_r ^ (prev_r >> 30));
    end
  end

endmodule

FILE: bench/mt19937_generator_test.sv
`timescale 1ns / 1ps
// mt19937_generator_test: self-checking bench for the MT19937 generator, with a shadow
// twister that predicts every drawn word. Depends on mtg_pkg and mt19937_generator.
module mt19937_generator_test;
  import mtg_pkg::*;

  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam int unsigned ITEM_TARGET = 2000;

  // Shadow copy of the twister state plus the words still owed by the block
  class twister_shadow;
    bit [31:0] words [N_WORDS];
    int unsigned position;
    bit seeded;
    bit [31:0] owed_words [$];
    int unsigned fault_count;
    int unsigned reseeds;
    int unsigned draws;
    int unsigned checked;

    // Called once per accepted command beat
    function void note_command(logic op, logic [31:0] seed);
      bit [31:0] p;
      bit [31:0] y;
      bit [31:0] v;
      int unsigned nxt;
      int unsigned far;
      if (op == OP_RESEED) begin
        reseeds++;
        words[0] = seed;
        for (int unsigned i = 1; i < N_WORDS; i++) begin
          p = words[i-1];
          words[i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        position = 0;
        seeded = 1'b1;
        return;
      end
      draws++;
      // unseeded draws return zero and leave the state alone
      if (!seeded) begin
        owed_words.push_back('0);
        return;
      end
      if (position >= N_WORDS) position = 0;
      // regenerate the whole state at the top of each block
      if (position == 0) begin
        for (int unsigned i = 0; i < N_WORDS; i++) begin
          nxt = (i + 1) % N_WORDS;
          far = (i + M_SHIFT) % N_WORDS;
          y = (words[i] & UPPER_MASK) | (words[nxt] & LOWER_MASK);
          v = words[far] ^ (y >> 1);
          if (y[0]) v = v ^ MATRIX_A;
          words[i] = v;
        end
      end
      // output tempering
      y = words[position];
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      owed_words.push_back(y);
      position = (position + 1) % N_WORDS;
    endfunction

    // Called once per out_valid beat
    function void check_word(logic [31:0] actual);
      bit [31:0] want;
      if (owed_words.size() == 0) begin
        $error("random_word: beat with no draw outstanding, actual %08h", actual);
        fault_count++;
      end else begin
        want = owed_words.pop_front();
        checked++;
        if (actual !== want) begin
          $error("random_word mismatch: expected %08h, actual %08h", want, actual);
          fault_count++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [31:0] in_seed_value;
  logic        out_valid;
  logic [31:0] out_random_word;

  twister_shadow shadow;
  int unsigned sent;

  mt19937_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor: note accepted beats before checking results of the same edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) shadow.note_command(in_opcode, in_seed_value);
      if (out_valid !== 1'b0) shadow.check_word(out_random_word);
    end
  end

  // Hold one command until the block takes it
  task automatic send_command(input logic op, input logic [31:0] seed);
    start <= 1'b1;
    in_opcode <= op;
    in_seed_value <= seed;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  // Random gap between beats; no gaps in one long stretch
  task automatic maybe_idle();
    int unsigned idle_pct;
    idle_pct = (sent >= 600 && sent < 900) ? 0 : 31;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_opcode <= 1'($urandom_range(1));
      in_seed_value <= $urandom;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 3)) @(posedge clk);
    end
  endtask

  // Stop sending until the block is idle and nothing is owed
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (shadow.owed_words.size() != 0 || busy !== 1'b0);
  endtask

  initial begin
    logic [31:0] seed;
    int unsigned kind;
    int unsigned run_len;
    bit first_run;

    shadow = new();
    sent = 0;
    first_run = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_DRAW;
    in_seed_value = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unseeded draws, zero and all-ones seeds, back-to-back reseeds
    send_command(OP_DRAW, 32'hFFFF_FFFF); maybe_idle();
    send_command(OP_DRAW, 32'h0000_0000); maybe_idle();
    send_command(OP_RESEED, 32'h0000_0000); maybe_idle();
    repeat (3) begin send_command(OP_DRAW, $urandom); maybe_idle(); end
    send_command(OP_RESEED, 32'd5489); maybe_idle();
    repeat (3) begin send_command(OP_DRAW, $urandom); maybe_idle(); end
    send_command(OP_RESEED, 32'hFFFF_FFFF); maybe_idle();
    send_command(OP_DRAW, 32'hFFFF_FFFF); maybe_idle();
    send_command(OP_DRAW, 32'h0000_0000); maybe_idle();
    send_command(OP_RESEED, 32'h8000_0000);
    send_command(OP_RESEED, 32'h0000_0001); maybe_idle();
    repeat (2) begin send_command(OP_DRAW, $urandom); maybe_idle(); end
    settle();

    // Random: mostly reseed followed by a run of draws, some stray reseeds and draw bursts
    while (sent < ITEM_TARGET) begin
      kind = $urandom_range(99);
      run_len = 0;
      if (kind < 85 || first_run) begin
        case ($urandom_range(15))
          0: seed = '0;
          1: seed = '1;
          2: seed = 32'h8000_0000;
          3: seed = 32'h0000_0001;
          default: seed = $urandom;
        endcase
        send_command(OP_RESEED, seed);
        maybe_idle();
        // first run is forced past a full block so the position wraps
        if (first_run) run_len = $urandom_range(630, 700);
        else if ($urandom_range(9) == 0) run_len = $urandom_range(620, 1300);
        else run_len = $urandom_range(1, 40);
        first_run = 1'b0;
      end else if (kind < 92) begin
        send_command(OP_RESEED, $urandom);
        maybe_idle();
      end else begin
        run_len = $urandom_range(1, 30);
      end
      // runs are cut short once the item budget is spent
      repeat (run_len) begin
        if (sent < ITEM_TARGET) begin
          send_command(OP_DRAW, $urandom);
          maybe_idle();
        end
      end
      if ($urandom_range(19) == 0) settle();
    end

    // Drain and let any reseed finish
    settle();
    repeat (20) @(posedge clk);
    if (shadow.owed_words.size() != 0) begin
      $error("random_word: %0d expected words never arrived", shadow.owed_words.size());
      shadow.fault_count++;
    end

    $display("run covered %0d commands: %0d reseeds and %0d draws", sent, shadow.reseeds,
             shadow.draws);
    $display("%0d words compared, %0d mismatches", shadow.checked, shadow.fault_count);
    if (shadow.fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_ram.sv
hw/rtl/mtg_seeder.sv
hw/rtl/mt19937_generator.sv
bench/mt19937_generator_test.sv
